[design/slm_pkg.sv]
// Shared types and Q16 constants for the skin likelihood matte pipeline.
// No dependencies.
package slm_pkg;

    // Q16 value saturated to 0..1.0 (65536 fits in 17 bits)
    typedef logic [16:0] unit_t;

    localparam int CH_IN_W     = 12;   // red, green, blue
    localparam int EXT_W       = 13;   // external_value, signed
    localparam int SKIN_W      = 11;   // skin_weight
    localparam int PIPE_STAGES = 9;    // compute stages ahead of the output register
    localparam int LATENCY     = PIPE_STAGES + 1;

    localparam int UNIT      = 65536;
    localparam int K_HALF    = 32768;
    localparam int K_YR      = 13933;
    localparam int K_YG      = 46871;
    localparam int K_YB      = 4732;
    localparam int K_CB      = 36962;
    localparam int K_CR      = 46727;
    localparam int K_CB_LO   = 18350;
    localparam int K_CB_HI   = 38011;
    localparam int K_CR_LO   = 28180;
    localparam int K_CR_HI   = 49152;
    localparam int K_Y_LO    = 2621;
    localparam int K_Y_HI    = 64225;
    localparam int K_FEATHER = 5243;
    localparam int K_RB_BIAS = 7864;
    localparam int K_GB_BIAS = 6554;
    localparam int K_BASE_W  = 22938;
    localparam int K_ORDER_W = 42598;

    // window ramp origins: rise starts at lo - feather, fall ends at hi + feather
    localparam int CB_RISE0 = K_CB_LO - K_FEATHER;
    localparam int CB_FALL0 = K_CB_HI + K_FEATHER;
    localparam int CR_RISE0 = K_CR_LO - K_FEATHER;
    localparam int CR_FALL0 = K_CR_HI + K_FEATHER;
    localparam int Y_RISE0  = K_Y_LO - K_FEATHER;
    localparam int Y_FALL0  = K_Y_HI + K_FEATHER;

    // channel-order ramps saturate at 1.0 above these differences (x4 and x5 slopes)
    localparam int RB_KNEE = 16384;
    localparam int GB_KNEE = 13107;

endpackage

[design/skin_likelihood_matte.sv]
// Skin likelihood matte: RGB pixel to Q1.10 skin weight, fully pipelined.
// Depends on slm_pkg.
//
// Usage
//   Pixel channel: red, green, blue (unsigned Q2.FRAC_BITS) and external_value
//   (signed Q3.FRAC_BITS) are taken as one beat at each rising edge where
//   start is high and busy is low. busy is always low: one pixel per clock.
//   Result channel: skin_weight is valid for exactly one cycle while done is
//   high. There is no back-pressure; the receiver must take every beat.
//   Config channel: cfg_data (use_external_matte) is written when cfg_valid
//   and cfg_ready are both high; cfg_ready is always high. Write only while
//   no pixel is in flight. The mode bit is sampled with each pixel.
// Timing
//   Throughput is one pixel per clock. Each pixel passes through the
//   nine-stage multiply chain (luma, chroma, three window products, order
//   weight) and then the output register.
// Reset
//   rst_n clears the stage valid bits, done and use_external_matte. Pixels in
//   flight at reset are dropped.
module skin_likelihood_matte
    import slm_pkg::*;
#(
    parameter int FRAC_BITS = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CH_IN_W-1:0]       red,
    input  logic [CH_IN_W-1:0]       green,
    input  logic [CH_IN_W-1:0]       blue,
    input  logic signed [EXT_W-1:0]  external_value,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_data,
    output logic                     done,
    output logic [SKIN_W-1:0]        skin_weight
);

    // ---------------------------------------------------------------------
    // Widths. Channels are widened to Q16, so everything follows from SHIFT.
    // ---------------------------------------------------------------------
    localparam int SHIFT = 16 - FRAC_BITS;
    localparam int CH_W  = CH_IN_W + SHIFT;          // Q16 channel / luma
    localparam int YP_W  = CH_W + 16;                // one luma product
    localparam int YS_W  = CH_W + 18;                // luma sum with rounding
    localparam int VW    = ((CH_W > 17) ? CH_W : 17) + 2; // signed Q16 values
    localparam int DW    = VW + 1;                   // window differences
    localparam int MW    = DW + 5;                   // difference times 25
    localparam int PW    = CH_W + 19;                // chroma products
    localparam int RND   = (SHIFT > 0) ? (1 << (SHIFT - 1)) : 0;
    localparam int ONE_Q = 1 << FRAC_BITS;

    localparam logic signed [VW-1:0] HALF_S = VW'(K_HALF);

    // Q16 product of two unit values, rounded to nearest
    function automatic unit_t mq16(input unit_t a, input unit_t b);
        logic [33:0] p;
        p = 34'(a) * 34'(b) + 34'(K_HALF);
        return p[32:16];
    endfunction

    // Rounded >>16 of a signed product (ties away from zero), plus 0.5
    function automatic logic signed [VW-1:0] chroma_off(input logic signed [PW-1:0] x);
        logic [PW-1:0]          mag;
        logic [PW-1:0]          q;
        logic signed [VW-1:0]   qs;
        mag = x[PW-1] ? PW'(-x) : PW'(x);
        q   = (mag + PW'(K_HALF)) >> 16;
        qs  = $signed(VW'(q));
        return x[PW-1] ? (HALF_S - qs) : (HALF_S + qs);
    endfunction

    // Feather ramp: d / 0.08 as d * 25 / 2, rounded, saturated to 0..1.0
    function automatic unit_t ramp_edge(input logic signed [DW-1:0] d);
        logic signed [MW-1:0] m;
        logic [MW-1:0]        h;
        unit_t                ramp;
        m = (MW'(d) <<< 4) + (MW'(d) <<< 3) + MW'(d);
        h = ($unsigned(m) + MW'(1)) >> 1;
        if (m[MW-1])
            ramp = '0;
        else if (h > MW'(UNIT))
            ramp = unit_t'(UNIT);
        else
            ramp = h[16:0];
        return ramp;
    endfunction

    // ---------------------------------------------------------------------
    // Handshakes and config
    // ---------------------------------------------------------------------
    logic accept;
    logic use_ext_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            use_ext_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            use_ext_reg <= cfg_data;
    end

    // ---------------------------------------------------------------------
    // Side pipe: valid, mode and clamped external value travel with the data
    // ---------------------------------------------------------------------
    logic [PIPE_STAGES-1:0] vld_reg;
    logic                   mode_reg [PIPE_STAGES];
    logic [SKIN_W-1:0]      ext_reg  [PIPE_STAGES];
    logic [16:0]            ext_next;

    always_comb
    begin
        if (external_value < 0)
            ext_next = '0;
        else if (18'(external_value) > 18'(ONE_Q))
            ext_next = 17'(ONE_Q);
        else
            ext_next = 17'(external_value);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[PIPE_STAGES-2:0], accept};
    end

    always_ff @(posedge clk)
    begin
        mode_reg[0] <= use_ext_reg;
        ext_reg[0]  <= ext_next[SKIN_W-1:0];
        for (int i = 1; i < PIPE_STAGES; i++)
        begin
            mode_reg[i] <= mode_reg[i-1];
            ext_reg[i]  <= ext_reg[i-1];
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: widen to Q16, luma products
    // ---------------------------------------------------------------------
    logic [CH_W-1:0] r_w, g_w, b_w;
    logic [CH_W-1:0] s1_r_reg, s1_g_reg, s1_b_reg;
    logic [YP_W-1:0] s1_pr_reg, s1_pg_reg, s1_pb_reg;
    logic [YP_W-1:0] s1_pr_next, s1_pg_next, s1_pb_next;

    always_comb
    begin
        r_w        = CH_W'(red) << SHIFT;
        g_w        = CH_W'(green) << SHIFT;
        b_w        = CH_W'(blue) << SHIFT;
        s1_pr_next = YP_W'(r_w) * YP_W'(K_YR);
        s1_pg_next = YP_W'(g_w) * YP_W'(K_YG);
        s1_pb_next = YP_W'(b_w) * YP_W'(K_YB);
    end

    always_ff @(posedge clk)
    begin
        s1_r_reg  <= r_w;
        s1_g_reg  <= g_w;
        s1_b_reg  <= b_w;
        s1_pr_reg <= s1_pr_next;
        s1_pg_reg <= s1_pg_next;
        s1_pb_reg <= s1_pb_next;
    end

    // ---------------------------------------------------------------------
    // Stage 2: luma sum, channel-order ramps
    // ---------------------------------------------------------------------
    logic [YS_W-1:0]      ysum;
    logic signed [VW-1:0] rbd, gbd;
    logic [CH_W-1:0]      s2_y_next, s2_y_reg, s2_r_reg, s2_b_reg;
    unit_t                s2_rb_next, s2_gb_next, s2_rb_reg, s2_gb_reg;

    always_comb
    begin
        ysum = YS_W'(s1_pr_reg) + YS_W'(s1_pg_reg) + YS_W'(s1_pb_reg) + YS_W'(K_HALF);
        s2_y_next = CH_W'(ysum >> 16);

        rbd = VW'($signed({1'b0, s1_r_reg})) - VW'($signed({1'b0, s1_b_reg}))
            + VW'(K_RB_BIAS);
        gbd = VW'($signed({1'b0, s1_g_reg})) - VW'($signed({1'b0, s1_b_reg}))
            + VW'(K_GB_BIAS);

        if (rbd < 0)
            s2_rb_next = '0;
        else if (rbd > VW'(RB_KNEE))
            s2_rb_next = unit_t'(UNIT);
        else
            s2_rb_next = unit_t'(rbd) << 2;

        if (gbd < 0)
            s2_gb_next = '0;
        else if (gbd > VW'(GB_KNEE))
            s2_gb_next = unit_t'(UNIT);
        else
            s2_gb_next = (unit_t'(gbd) << 2) + unit_t'(gbd);
    end

    always_ff @(posedge clk)
    begin
        s2_y_reg  <= s2_y_next;
        s2_r_reg  <= s1_r_reg;
        s2_b_reg  <= s1_b_reg;
        s2_rb_reg <= s2_rb_next;
        s2_gb_reg <= s2_gb_next;
    end

    // ---------------------------------------------------------------------
    // Stage 3: chroma products, order term, luma ramps
    // ---------------------------------------------------------------------
    logic signed [CH_W:0]   db, dr;
    logic signed [DW-1:0]   ly_rise_d, ly_fall_d;
    logic signed [PW-1:0]   s3_cbm_next, s3_crm_next, s3_cbm_reg, s3_crm_reg;
    unit_t                  s3_ord_reg, s3_lr_reg, s3_lf_reg;

    always_comb
    begin
        db = $signed({1'b0, s2_b_reg}) - $signed({1'b0, s2_y_reg});
        dr = $signed({1'b0, s2_r_reg}) - $signed({1'b0, s2_y_reg});
        s3_cbm_next = PW'(db) * PW'(K_CB);
        s3_crm_next = PW'(dr) * PW'(K_CR);
        ly_rise_d = DW'($signed({1'b0, s2_y_reg})) - DW'(Y_RISE0);
        ly_fall_d = DW'(Y_FALL0) - DW'($signed({1'b0, s2_y_reg}));
    end

    always_ff @(posedge clk)
    begin
        s3_cbm_reg <= s3_cbm_next;
        s3_crm_reg <= s3_crm_next;
        s3_ord_reg <= mq16(s2_rb_reg, s2_gb_reg);
        s3_lr_reg  <= ramp_edge(ly_rise_d);
        s3_lf_reg  <= ramp_edge(ly_fall_d);
    end

    // ---------------------------------------------------------------------
    // Stage 4: offset Cb/Cr, luma window, order weight product
    // ---------------------------------------------------------------------
    logic signed [VW-1:0] s4_cb_reg, s4_cr_reg;
    unit_t                s4_lum_reg, s4_wq_reg;

    always_ff @(posedge clk)
    begin
        s4_cb_reg  <= chroma_off(s3_cbm_reg);
        s4_cr_reg  <= chroma_off(s3_crm_reg);
        s4_lum_reg <= mq16(s3_lr_reg, s3_lf_reg);
        s4_wq_reg  <= mq16(unit_t'(K_ORDER_W), s3_ord_reg);
    end

    // ---------------------------------------------------------------------
    // Stage 5: Cb/Cr ramps, final weight
    // ---------------------------------------------------------------------
    logic signed [DW-1:0] cb_rise_d, cb_fall_d, cr_rise_d, cr_fall_d;
    unit_t                s5_cbr_reg, s5_cbf_reg, s5_crr_reg, s5_crf_reg;
    unit_t                s5_lum_reg, s5_w_reg;

    always_comb
    begin
        cb_rise_d = DW'(s4_cb_reg) - DW'(CB_RISE0);
        cb_fall_d = DW'(CB_FALL0) - DW'(s4_cb_reg);
        cr_rise_d = DW'(s4_cr_reg) - DW'(CR_RISE0);
        cr_fall_d = DW'(CR_FALL0) - DW'(s4_cr_reg);
    end

    always_ff @(posedge clk)
    begin
        s5_cbr_reg <= ramp_edge(cb_rise_d);
        s5_cbf_reg <= ramp_edge(cb_fall_d);
        s5_crr_reg <= ramp_edge(cr_rise_d);
        s5_crf_reg <= ramp_edge(cr_fall_d);
        s5_lum_reg <= s4_lum_reg;
        s5_w_reg   <= s4_wq_reg + unit_t'(K_BASE_W);   // tops out at exactly 1.0
    end

    // ---------------------------------------------------------------------
    // Stages 6..9: window products, chroma x luma, weighting, saturate
    // ---------------------------------------------------------------------
    unit_t s6_cbw_reg, s6_crw_reg, s6_lum_reg, s6_w_reg;
    unit_t s7_chr_reg, s7_lum_reg, s7_w_reg;
    unit_t s8_cl_reg, s8_w_reg;
    unit_t s9_q_next, s9_q_reg;

    always_comb
    begin
        s9_q_next = mq16(s8_cl_reg, s8_w_reg);
        if (s9_q_next > unit_t'(UNIT))
            s9_q_next = unit_t'(UNIT);
    end

    always_ff @(posedge clk)
    begin
        s6_cbw_reg <= mq16(s5_cbr_reg, s5_cbf_reg);
        s6_crw_reg <= mq16(s5_crr_reg, s5_crf_reg);
        s6_lum_reg <= s5_lum_reg;
        s6_w_reg   <= s5_w_reg;
        s7_chr_reg <= mq16(s6_cbw_reg, s6_crw_reg);
        s7_lum_reg <= s6_lum_reg;
        s7_w_reg   <= s6_w_reg;
        s8_cl_reg  <= mq16(s7_chr_reg, s7_lum_reg);
        s8_w_reg   <= s7_w_reg;
        s9_q_reg   <= s9_q_next;
    end

    // ---------------------------------------------------------------------
    // Output register: round Q16 to Q.FRAC_BITS, or pass the external matte
    // ---------------------------------------------------------------------
    logic [16:0]       fin;
    logic [SKIN_W-1:0] skin_weight_next, skin_weight_reg;
    logic              done_reg;

    always_comb
    begin
        fin = 17'((18'(s9_q_reg) + 18'(RND)) >> SHIFT);
        if (fin > 17'(ONE_Q))
            fin = 17'(ONE_Q);
        if (mode_reg[PIPE_STAGES-1])
            skin_weight_next = ext_reg[PIPE_STAGES-1];
        else
            skin_weight_next = fin[SKIN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg[PIPE_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        skin_weight_reg <= skin_weight_next;
    end

    assign done        = done_reg;
    assign skin_weight = skin_weight_reg;

`ifndef SYNTHESIS
    // every accepted pixel comes out after the fixed latency
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted pixel did not produce a result beat");

    // no result beat without a matching accepted pixel
    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result beat without matching pixel");

    // result never exceeds 1.0 when it fits the port
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((FRAC_BITS > 10) || (17'(skin_weight) <= 17'(ONE_Q))))
        else $error("skin_weight above 1.0");
`endif

endmodule

[tb/skin_likelihood_matte_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for skin_likelihood_matte: directed and random pixels,
// both matte modes, with a Q16 skin-likelihood predictor. Needs slm_pkg and the block.
module skin_likelihood_matte_test;
    import slm_pkg::*;

    localparam int FRAC       = 10;
    localparam int STALL_MAX  = 1000;   // cycles with no beat of any kind
    localparam int TAIL_WAIT  = LATENCY + 2;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [CH_IN_W-1:0]      red;
    logic [CH_IN_W-1:0]      green;
    logic [CH_IN_W-1:0]      blue;
    logic signed [EXT_W-1:0] external_value;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic                    cfg_data;
    logic                    done;
    logic [SKIN_W-1:0]       skin_weight;

    // predictor's copy of the mode register
    logic                    matte_mode;
    logic [SKIN_W-1:0]       pending_weights[$];
    int                      mismatches = 0;
    int                      quiet_cycles = 0;
    int                      idle_pct = 0;

    skin_likelihood_matte #(.FRAC_BITS(FRAC)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .external_value (external_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .done           (done),
        .skin_weight    (skin_weight)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Q16 arithmetic: rounding is to nearest, ties away from zero
    // ------------------------------------------------------------------
    function automatic longint shr_round(longint x, int s);
        longint half;
        half = (s > 0) ? (longint'(1) << (s - 1)) : 0;
        if (x >= 0)
            return (x + half) >>> s;
        return -((-x + half) >>> s);
    endfunction

    function automatic longint q16_mul(longint a, longint b);
        return shr_round(a * b, 16);
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v < 0)
            return 0;
        if (v > UNIT)
            return UNIT;
        return v;
    endfunction

    // feathered window: linear ramps of slope 1/0.08 (= 25/2) on both edges
    function automatic longint band_gain(longint v, longint lo, longint hi);
        longint rise;
        longint fall;
        rise = clamp_unit(shr_round((v - (lo - K_FEATHER)) * 25, 1));
        fall = clamp_unit(shr_round(((hi + K_FEATHER) - v) * 25, 1));
        return q16_mul(rise, fall);
    endfunction

    function automatic logic [SKIN_W-1:0] predict_skin_weight(
        logic [CH_IN_W-1:0] r_in, logic [CH_IN_W-1:0] g_in,
        logic [CH_IN_W-1:0] b_in, logic signed [EXT_W-1:0] ext_in, logic ext_mode);
        longint one;
        longint r, g, b, y, cb, cr;
        longint chroma, luma_gain, order, weight, q16, res;
        one = longint'(1) << FRAC;
        if (ext_mode)
        begin
            res = longint'(ext_in);
            if (res < 0)
                res = 0;
            if (res > one)
                res = one;
            return res[SKIN_W-1:0];
        end
        r = longint'(r_in) << (16 - FRAC);
        g = longint'(g_in) << (16 - FRAC);
        b = longint'(b_in) << (16 - FRAC);
        y  = shr_round(K_YR * r + K_YG * g + K_YB * b, 16);
        cb = q16_mul(b - y, K_CB) + K_HALF;
        cr = q16_mul(r - y, K_CR) + K_HALF;
        chroma    = q16_mul(band_gain(cb, K_CB_LO, K_CB_HI), band_gain(cr, K_CR_LO, K_CR_HI));
        luma_gain = band_gain(y, K_Y_LO, K_Y_HI);
        // channel order: red over blue and green over blue push the weight up
        order  = q16_mul(clamp_unit((r - b + K_RB_BIAS) * 4),
                         clamp_unit((g - b + K_GB_BIAS) * 5));
        weight = K_BASE_W + q16_mul(K_ORDER_W, order);
        q16    = clamp_unit(q16_mul(q16_mul(chroma, luma_gain), weight));
        res    = (q16 + (longint'(1) << (15 - FRAC))) >>> (16 - FRAC);
        if (res > one)
            res = one;
        return res[SKIN_W-1:0];
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: checks each result beat, records each pixel beat and tracks
    // the mode register; also the no-progress watchdog.
    // Order matters: the result check goes before the push of a new pixel.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matte_mode   <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_weights.size() == 0)
                    report_mismatch("result beat with nothing pending", skin_weight, 0);
                else if (skin_weight !== pending_weights[0])
                begin
                    report_mismatch("skin_weight", skin_weight, pending_weights[0]);
                    void'(pending_weights.pop_front());
                end
                else
                    void'(pending_weights.pop_front());
            end
            if (start && !busy)
                pending_weights.push_back(
                    predict_skin_weight(red, green, blue, external_value, matte_mode));
            if (cfg_valid && cfg_ready)
                matte_mode <= cfg_data;

            if (done || (start && !busy) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= STALL_MAX)
            begin
                $display("skin_likelihood_matte_test NOT OK");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks: inputs move on the falling edge only
    // ------------------------------------------------------------------
    task automatic send_pixel(int r, int g, int b, int ext);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start          <= 1'b1;
        red            <= CH_IN_W'(r);
        green          <= CH_IN_W'(g);
        blue           <= CH_IN_W'(b);
        external_value <= EXT_W'(ext);
        do
            @(posedge clk);
        while (busy);
    endtask

    // stop sending and let every pending result come back, then the pipe flush
    task automatic drain_pixels();
        @(negedge clk);
        start <= 1'b0;
        while (pending_weights.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
    endtask

    task automatic write_matte_mode(logic mode);
        drain_pixels();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // color path from reset mode: black, white, primaries, skin tones,
    // channels above 1.0 (luma window takes the weight down)
    task automatic test_color_extremes();
        int px[14][3] = '{
            '{0, 0, 0},       '{4095, 4095, 4095}, '{1024, 1024, 1024},
            '{4095, 0, 0},    '{0, 4095, 0},       '{0, 0, 4095},
            '{800, 560, 420}, '{900, 650, 500},    '{600, 420, 330},
            '{1024, 700, 550},'{1500, 1100, 900},  '{2048, 1500, 1200},
            '{100, 70, 50},   '{4095, 4095, 0}};
        idle_pct = 0;
        foreach (px[i])
            send_pixel(px[i][0], px[i][1], px[i][2], $urandom_range(8191));
    endtask

    // pass-through: negative clamps to 0, above 1.0 clamps to 1024
    task automatic test_external_clamp();
        int ext_vals[8] = '{-4096, -1, 0, 1, 512, 1024, 1025, 4095};
        write_matte_mode(1'b1);
        foreach (ext_vals[i])
            send_pixel($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                       ext_vals[i]);
    endtask

    // random pixels; most look like skin so the windows open up,
    // the rest are loose low-range and full-range noise
    task automatic test_random_pixels(logic mode, int gap_pct, int count, bit hold_mid);
        int r, g, b, ext, pick;
        write_matte_mode(mode);
        idle_pct = gap_pct;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                r = $urandom_range(1150, 250);
                g = r * $urandom_range(90, 45) / 100;
                b = g * $urandom_range(100, 40) / 100;
            end
            else if (pick < 85)
            begin
                r = $urandom_range(1100);
                g = $urandom_range(1100);
                b = $urandom_range(1100);
            end
            else
            begin
                r = $urandom_range(4095);
                g = $urandom_range(4095);
                b = $urandom_range(4095);
            end
            if (mode && $urandom_range(1))
                ext = $urandom_range(1100) - 50;
            else
                ext = $urandom_range(8191);
            send_pixel(r, g, b, ext);
            // hold off until the pipe is empty, then resume
            if (hold_mid && n == count / 2)
                drain_pixels();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        red            = '0;
        green          = '0;
        blue           = '0;
        external_value = '0;
        cfg_valid      = 1'b0;
        cfg_data       = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_color_extremes();
        test_external_clamp();
        test_random_pixels(1'b0, 0,  250, 1'b0);
        test_random_pixels(1'b1, 68, 150, 1'b0);
        test_random_pixels(1'b0, 68, 250, 1'b1);
        test_random_pixels(1'b0, 29, 200, 1'b0);
        test_random_pixels(1'b1, 29, 100, 1'b0);
        drain_pixels();

        if (mismatches == 0)
            $display("skin_likelihood_matte_test OK");
        else
            $display("skin_likelihood_matte_test NOT OK");
        $finish;
    end

endmodule
